// ----- hdl/qte_pkg.sv -----
`default_nettype none
package qte_pkg;

  // default and limits of the cordic iteration count
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  // digit pairs of the 58-bit radicand, one result bit per stage
  localparam int SQ_STEPS = 29;

  // datapath widths
  localparam int OW = 34;  // atan2 operands at scale 2^28
  localparam int CW = 38;  // cordic x/y with gain headroom
  localparam int AW = 28;  // angle in degrees at scale 2^16

  // lane positions
  localparam int LN_ROLL  = 0;
  localparam int LN_PITCH = 1;
  localparam int LN_YAW   = 2;

  localparam logic signed [OW-1:0] ONE_Q28     = 34'sd268435456;
  localparam logic signed [AW-1:0] HALF_Q16    = 28'sd11796480;
  localparam logic signed [AW-1:0] QUARTER_Q16 = 28'sd5898240;
  localparam logic signed [AW-1:0] ROUND_Q16   = 28'sd256;
  localparam logic signed [AW-1:0] HALF_U      = 28'sd23040;
  localparam logic signed [AW-1:0] FULL_U      = 28'sd46080;
  localparam logic signed [AW-1:0] QUARTER_U   = 28'sd11520;

  typedef struct packed {
    logic signed [31:0] wx;
    logic signed [31:0] yz;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] wz;
    logic signed [31:0] xy;
    logic signed [31:0] zz;
    logic signed [31:0] wy;
    logic signed [31:0] zx;
  } prod_t;

  typedef struct packed {
    logic signed [OW-1:0] roll_y;
    logic signed [OW-1:0] roll_x;
    logic signed [OW-1:0] yaw_y;
    logic signed [OW-1:0] yaw_x;
    logic signed [OW-1:0] ps;
    logic                 sat;
    logic                 sat_neg;
  } opnd_t;

  typedef struct packed {
    opnd_t       op;
    logic [27:0] mag;
  } st1_t;

  typedef struct packed {
    opnd_t       op;
    logic [55:0] msq;
  } st2_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [28:0] root;
    logic [57:0] vsh;
  } sq_t;

  typedef struct packed {
    opnd_t op;
    sq_t   sq;
  } sqs_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
    logic                 fixd;
  } lane_t;

  typedef struct packed {
    lane_t [2:0] ln;
    logic        sat;
    logic        sat_neg;
  } cst_t;

  // atan(2^-i) in degrees at scale 2^16, rounded
  function automatic logic signed [AW-1:0] atan_q16(input logic [4:0] i);
    logic signed [AW-1:0] r;
    unique case (i)
      5'd0:    r = 28'sd2949120;
      5'd1:    r = 28'sd1740967;
      5'd2:    r = 28'sd919879;
      5'd3:    r = 28'sd466945;
      5'd4:    r = 28'sd234379;
      5'd5:    r = 28'sd117304;
      5'd6:    r = 28'sd58666;
      5'd7:    r = 28'sd29335;
      5'd8:    r = 28'sd14668;
      5'd9:    r = 28'sd7334;
      5'd10:   r = 28'sd3667;
      5'd11:   r = 28'sd1833;
      5'd12:   r = 28'sd917;
      5'd13:   r = 28'sd458;
      5'd14:   r = 28'sd229;
      5'd15:   r = 28'sd115;
      5'd16:   r = 28'sd57;
      5'd17:   r = 28'sd29;
      5'd18:   r = 28'sd14;
      5'd19:   r = 28'sd7;
      5'd20:   r = 28'sd4;
      5'd21:   r = 28'sd2;
      5'd22:   r = 28'sd1;
      default: r = 28'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [OW-1:0] sx34(input logic signed [31:0] v);
    return {{(OW-32){v[31]}}, v};
  endfunction

  // sums of products into atan2 operands and the pitch sine
  function automatic st1_t form_opnd(input prod_t p);
    st1_t                 r;
    logic signed [OW-1:0] m;
    r.op.roll_y = (sx34(p.wx) + sx34(p.yz)) <<< 1;
    r.op.roll_x = ONE_Q28 - ((sx34(p.xx) + sx34(p.yy)) <<< 1);
    r.op.yaw_y  = (sx34(p.wz) + sx34(p.xy)) <<< 1;
    r.op.yaw_x  = ONE_Q28 - ((sx34(p.yy) + sx34(p.zz)) <<< 1);
    r.op.ps     = (sx34(p.wy) + sx34(p.zx)) <<< 1;
    r.op.sat     = (r.op.ps >= ONE_Q28) || (r.op.ps <= -ONE_Q28);
    r.op.sat_neg = r.op.ps[OW-1];
    m = r.op.ps[OW-1] ? -r.op.ps : r.op.ps;
    r.mag = m[27:0];
    return r;
  endfunction

  // one restoring square root step, two radicand bits in
  function automatic sq_t sq_step(input sq_t a);
    sq_t         r;
    logic [31:0] rs;
    logic [31:0] trial;
    rs    = {a.rem[29:0], a.vsh[57:56]};
    trial = {1'b0, a.root, 2'b01};
    r.vsh = {a.vsh[55:0], 2'b00};
    if (rs >= trial) begin
      r.rem  = rs - trial;
      r.root = {a.root[27:0], 1'b1};
    end else begin
      r.rem  = rs;
      r.root = {a.root[27:0], 1'b0};
    end
    return r;
  endfunction

  // exact axes and left half plane before the iterations
  function automatic lane_t lane_init(input logic signed [OW-1:0] y,
                                      input logic signed [OW-1:0] x);
    lane_t r;
    r.x    = {{(CW-OW){x[OW-1]}}, x};
    r.y    = {{(CW-OW){y[OW-1]}}, y};
    r.ang  = '0;
    r.fixd = 1'b0;
    if (y == '0) begin
      r.fixd = 1'b1;
      r.ang  = x[OW-1] ? HALF_Q16 : '0;
    end else if (x == '0) begin
      r.fixd = 1'b1;
      r.ang  = y[OW-1] ? -QUARTER_Q16 : QUARTER_Q16;
    end else if (x[OW-1]) begin
      r.ang = y[OW-1] ? -HALF_Q16 : HALF_Q16;
      r.x   = -r.x;
      r.y   = -r.y;
    end
    return r;
  endfunction

  // one vectoring iteration
  function automatic lane_t cordic_step(input lane_t a, input logic [4:0] i);
    lane_t                r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    r  = a;
    xs = a.x >>> i;
    ys = a.y >>> i;
    if (!a.fixd) begin
      if (a.y[CW-1]) begin
        r.x   = a.x - ys;
        r.y   = a.y + xs;
        r.ang = a.ang - atan_q16(i);
      end else begin
        r.x   = a.x + ys;
        r.y   = a.y - xs;
        r.ang = a.ang + atan_q16(i);
      end
    end
    return r;
  endfunction

  // round to 1/128 degree
  function automatic logic signed [AW-1:0] to_units(input logic signed [AW-1:0] a);
    return (a + ROUND_Q16) >>> 9;
  endfunction

  function automatic logic [15:0] wrap_units(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] u;
    u = to_units(a);
    if (u > HALF_U) u = u - FULL_U;
    if (u < -HALF_U) u = u + FULL_U;
    return u[15:0];
  endfunction

  function automatic logic [14:0] clamp_units(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] u;
    u = to_units(a);
    if (u > QUARTER_U) u = QUARTER_U;
    if (u < -QUARTER_U) u = -QUARTER_U;
    return u[14:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/quaternion_to_euler_angles.sv -----
`default_nettype none
// Quaternion to ZYX Euler angles. Each input beat carries w, x, y, z in
// signed Q1.14; each output beat gives roll, pitch and yaw in 1/128 degree
// plus a flag in tuser that is set when the pitch sine reached magnitude one
// and pitch was forced to +/-90 degrees. The block takes one beat every
// cycle while the output is not stalled and delivers one result per beat,
// in order. The pipeline has one product stage, one sum stage, one
// squaring stage, 29 stages of the bit-per-stage square root for the pitch
// cosine, one quadrant stage, one stage per cordic iteration and the output
// register. A stall on the output side holds the whole pipeline, so in_tready
// follows out_tready while a result is waiting.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // roll_deg, pitch_deg, yaw_deg, zero pad
  output logic             out_tuser   // pitch_saturated
);

  localparam int SQ  = qte_pkg::SQ_STEPS;
  localparam int NST = 5 + SQ + CORDIC_STEPS;

  logic           en;
  logic [NST-1:0] vld_r;

  qte_pkg::prod_t prod_r;
  qte_pkg::st1_t  st1_r;
  qte_pkg::st2_t  st2_r;
  qte_pkg::sqs_t  sqs_r [SQ];
  qte_pkg::cst_t  prep_r;
  qte_pkg::cst_t  cs_r [CORDIC_STEPS];

  logic [15:0] roll_r;
  logic [14:0] pitch_r;
  logic [15:0] yaw_r;
  logic        sat_r;

  // whole pipeline advances unless the output beat is stuck
  assign en        = !vld_r[NST-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r.wx <= $signed(in_tdata[15:0])  * $signed(in_tdata[31:16]);
      prod_r.yz <= $signed(in_tdata[47:32]) * $signed(in_tdata[63:48]);
      prod_r.xx <= $signed(in_tdata[31:16]) * $signed(in_tdata[31:16]);
      prod_r.yy <= $signed(in_tdata[47:32]) * $signed(in_tdata[47:32]);
      prod_r.wz <= $signed(in_tdata[15:0])  * $signed(in_tdata[63:48]);
      prod_r.xy <= $signed(in_tdata[31:16]) * $signed(in_tdata[47:32]);
      prod_r.zz <= $signed(in_tdata[63:48]) * $signed(in_tdata[63:48]);
      prod_r.wy <= $signed(in_tdata[15:0])  * $signed(in_tdata[47:32]);
      prod_r.zx <= $signed(in_tdata[63:48]) * $signed(in_tdata[31:16]);
    end
  end

  // operand sums, pitch sine magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      st1_r <= qte_pkg::form_opnd(prod_r);
    end
  end

  // square of the pitch sine
  always_ff @(posedge clk) begin
    if (en) begin
      st2_r.op  <= st1_r.op;
      st2_r.msq <= 56'(st1_r.mag) * 56'(st1_r.mag);
    end
  end

  // square root of 1 - s^2, one root bit per stage
  genvar j;
  generate
    for (j = 0; j < SQ; j++) begin : g_sq
      if (j == 0) begin : g_first
        qte_pkg::sq_t sq_in;
        always_comb begin
          sq_in.rem  = '0;
          sq_in.root = '0;
          sq_in.vsh  = (58'd1 << 56) - {2'b00, st2_r.msq};
        end
        always_ff @(posedge clk) begin
          if (en) begin
            sqs_r[j].op <= st2_r.op;
            sqs_r[j].sq <= qte_pkg::sq_step(sq_in);
          end
        end
      end else begin : g_rest
        always_ff @(posedge clk) begin
          if (en) begin
            sqs_r[j].op <= sqs_r[j-1].op;
            sqs_r[j].sq <= qte_pkg::sq_step(sqs_r[j-1].sq);
          end
        end
      end
    end
  endgenerate

  // quadrant setup for the three lanes
  always_ff @(posedge clk) begin
    if (en) begin
      prep_r.ln[qte_pkg::LN_ROLL] <=
        qte_pkg::lane_init(sqs_r[SQ-1].op.roll_y, sqs_r[SQ-1].op.roll_x);
      prep_r.ln[qte_pkg::LN_PITCH] <=
        qte_pkg::lane_init(sqs_r[SQ-1].op.ps,
                           {{(qte_pkg::OW-29){1'b0}}, sqs_r[SQ-1].sq.root});
      prep_r.ln[qte_pkg::LN_YAW] <=
        qte_pkg::lane_init(sqs_r[SQ-1].op.yaw_y, sqs_r[SQ-1].op.yaw_x);
      prep_r.sat     <= sqs_r[SQ-1].op.sat;
      prep_r.sat_neg <= sqs_r[SQ-1].op.sat_neg;
    end
  end

  // cordic iterations, one per stage
  genvar i;
  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_cs
      qte_pkg::cst_t cs_in;
      if (i == 0) begin : g_first
        assign cs_in = prep_r;
      end else begin : g_rest
        assign cs_in = cs_r[i-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < 3; k++) begin
            cs_r[i].ln[k] <= qte_pkg::cordic_step(cs_in.ln[k], 5'(i));
          end
          cs_r[i].sat     <= cs_in.sat;
          cs_r[i].sat_neg <= cs_in.sat_neg;
        end
      end
    end
  endgenerate

  // rounding, wrap and pitch limits into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      roll_r <= qte_pkg::wrap_units(cs_r[CORDIC_STEPS-1].ln[qte_pkg::LN_ROLL].ang);
      yaw_r  <= qte_pkg::wrap_units(cs_r[CORDIC_STEPS-1].ln[qte_pkg::LN_YAW].ang);
      sat_r  <= cs_r[CORDIC_STEPS-1].sat;
      if (cs_r[CORDIC_STEPS-1].sat) begin
        pitch_r <= cs_r[CORDIC_STEPS-1].sat_neg ? qte_pkg::clamp_units(-qte_pkg::HALF_Q16)
                                                : qte_pkg::clamp_units(qte_pkg::HALF_Q16);
      end else begin
        pitch_r <= qte_pkg::clamp_units(cs_r[CORDIC_STEPS-1].ln[qte_pkg::LN_PITCH].ang);
      end
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {1'b0, yaw_r, pitch_r, roll_r};
  assign out_tuser  = sat_r;

endmodule
`default_nettype wire

// ----- hdl/qte_checker.sv -----
`default_nettype none
module qte_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tuser
);

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // input side only blocked by a waiting result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stall");

  // forced pitch is exactly +/-90 degrees
  a_sat_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[30:16] == 15'd11520) || (out_tdata[30:16] == 15'h5300))
    else $error("saturated pitch not at +/-90");

  // pitch stays within +/-90 degrees
  a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[30:16]) <= 15'sd11520) &&
                   ($signed(out_tdata[30:16]) >= -15'sd11520))
    else $error("pitch out of range");

  // roll stays within +/-180 degrees
  a_roll_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd23040) &&
                   ($signed(out_tdata[15:0]) >= -16'sd23040))
    else $error("roll out of range");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
